// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the NAL start-code converter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) else $error(msg);

`endif

// ----- rtl/lpna_pkg.sv -----
// Shared types and constants for the length-prefixed NAL to Annex B converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpna_pkg;

  localparam int COUNT_W    = 24;              // payload byte counter width, 16..32
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] LFB_RESET = 3'd4;
  localparam logic [2:0] LFB_MIN   = 3'd1;
  localparam logic [2:0] LFB_MAX   = 3'd4;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;
  localparam logic [1:0] SC_LAST_IDX = 2'd3;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_COPY,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_START,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       fin;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lpna_front.sv -----
// Front end: parses length prefixes, tracks payload, emits one command per payload byte and per length field.
// Depends on lpna_pkg.
`default_nettype none

module lpna_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [2:0]      cfg_wr_data,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic [23:0]     bytes_after,
  input  wire logic            block_corrupted,
  output logic                 push,
  output lpna_pkg::cmd_t       push_cmd
);
  import lpna_pkg::*;

  logic [2:0]         lfb_r;
  phase_t             phase_r, phase_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [2:0]         seen_r, seen_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;

  logic [2:0]         lsize;
  logic [COUNT_W-1:0] after_cnt;
  logic               block_end;
  logic [31:0]        acc_shift;
  logic [2:0]         seen_inc;
  logic               len_done;
  logic               size_bad;
  logic [COUNT_W-1:0] left_dec;
  logic               copy_fin;

  // Out-of-range register values clamp into 1..4.
  always_comb begin
    if (lfb_r < LFB_MIN) begin
      lsize = LFB_MIN;
    end else if (lfb_r > LFB_MAX) begin
      lsize = LFB_MAX;
    end else begin
      lsize = lfb_r;
    end
  end

  assign after_cnt = COUNT_W'(bytes_after);
  assign block_end = (after_cnt == '0);
  assign acc_shift = {acc_r[23:0], data_byte};
  assign seen_inc  = seen_r + 3'd1;
  assign len_done  = (seen_inc >= lsize);
  assign size_bad  = (acc_shift == 32'd0) || ((lsize == LFB_MAX) && acc_shift[31]) ||
                     (acc_shift > 32'(after_cnt));
  assign left_dec  = left_r - COUNT_W'(1);
  assign copy_fin  = (left_dec == '0) || block_end;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (block_end) begin
        phase_nxt = PH_LEN;
      end else if (block_corrupted) begin
        phase_nxt = PH_SKIP;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            if (len_done) begin
              phase_nxt = size_bad ? PH_SKIP : PH_COPY;
            end
          end
          PH_COPY: begin
            if (copy_fin) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_SKIP: phase_nxt = PH_SKIP;
          default: phase_nxt = PH_LEN;
        endcase
      end
    end
  end

  // Datapath and command output
  always_comb begin
    acc_nxt       = acc_r;
    seen_nxt      = seen_r;
    left_nxt      = left_r;
    push          = 1'b0;
    push_cmd.kind = CMD_BYTE;
    push_cmd.data = data_byte;
    push_cmd.fin  = 1'b0;
    if (accept && !block_corrupted) begin
      unique case (phase_r)
        PH_LEN: begin
          if (len_done) begin
            acc_nxt  = 32'd0;
            seen_nxt = 3'd0;
            push     = 1'b1;
            if (size_bad) begin
              push_cmd.kind = CMD_REPORT;
            end else begin
              push_cmd.kind = CMD_START;
              left_nxt      = COUNT_W'(acc_shift);
            end
          end else begin
            acc_nxt  = acc_shift;
            seen_nxt = seen_inc;
          end
        end
        PH_COPY: begin
          push          = 1'b1;
          push_cmd.kind = CMD_BYTE;
          push_cmd.fin  = copy_fin;
          left_nxt      = copy_fin ? '0 : left_dec;
        end
        PH_SKIP: ;
        default: ;
      endcase
    end
    // Clear all counters at block end.
    if (accept && block_end) begin
      acc_nxt  = 32'd0;
      seen_nxt = 3'd0;
      left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfb_r   <= LFB_RESET;
      phase_r <= PH_LEN;
      acc_r   <= 32'd0;
      seen_r  <= 3'd0;
      left_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        lfb_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpna_cmd_fifo.sv -----
// Short command queue between the parsing front end and the output back end.
// Depends on lpna_pkg.
`default_nettype none

module lpna_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lpna_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output lpna_pkg::cmd_t       head,
  output logic                 empty,
  output logic                 full
);
  import lpna_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpna_back.sv -----
// Back end: expands queued commands into result bytes in a registered output stage.
// Depends on lpna_pkg.
`default_nettype none

module lpna_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lpna_pkg::cmd_t  head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_out_byte,
  output logic                 out_nal_begin,
  output logic                 out_nal_finish,
  output logic                 out_status,
  output logic                 out_run_last
);
  import lpna_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [7:0] byte_r;
  logic       begin_r, finish_r, status_r, last_r;
  logic       load;
  logic       last_sub;
  logic [7:0] byte_nxt;
  logic       begin_nxt, finish_nxt, status_nxt, last_nxt;

  assign load     = !empty && (!valid_r || out_ready);
  assign last_sub = (head.kind != CMD_START) || (sub_r == SC_LAST_IDX);
  assign pop      = load && last_sub;

  always_comb begin
    byte_nxt   = head.data;
    begin_nxt  = 1'b0;
    finish_nxt = 1'b0;
    status_nxt = 1'b0;
    last_nxt   = 1'b1;
    unique case (head.kind)
      CMD_BYTE: begin
        finish_nxt = head.fin;
      end
      CMD_START: begin
        byte_nxt  = (sub_r == SC_LAST_IDX) ? SC_ONE : SC_ZERO;
        begin_nxt = (sub_r == 2'd0);
        last_nxt  = (sub_r == SC_LAST_IDX);
      end
      CMD_REPORT: begin
        byte_nxt   = SC_ZERO;
        status_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = last_sub ? 2'd0 : sub_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      begin_r  <= begin_nxt;
      finish_r <= finish_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_out_byte   = byte_r;
  assign out_nal_begin  = begin_r;
  assign out_nal_finish = finish_r;
  assign out_status     = status_r;
  assign out_run_last   = last_r;

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_nal_to_annexb_unit.sv -----
// Length-prefixed NAL to Annex B converter, top level.
// Throughput: one input byte per cycle while the command queue is not full; a
// start code expands into four output bytes, which the four-entry command queue
// absorbs until it fills.
// Reset (rst_n, synchronous, active low) clears queue, output stage and parser
// state, and sets the length field size to 4 bytes.
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_nal_to_annexb_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [23:0] in_bytes_after,
  input  wire logic        in_block_corrupted,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_out_byte,
  output logic             out_nal_begin,
  output logic             out_nal_finish,
  output logic             out_status,
  output logic             out_run_last
);
  import lpna_pkg::*;

  logic in_accept;
  logic fifo_push, fifo_pop, fifo_empty, fifo_full;
  cmd_t push_cmd, head_cmd;
  logic report_seen, report_ok;
  logic begin_seen, begin_ok, begin_fire;
  logic sc_mid_ok;

  assign in_ready  = !fifo_full;
  assign in_accept = in_valid && in_ready;

  lpna_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .accept          (in_accept),
    .data_byte       (in_data_byte),
    .bytes_after     (in_bytes_after),
    .block_corrupted (in_block_corrupted),
    .push            (fifo_push),
    .push_cmd        (push_cmd)
  );

  lpna_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .head     (head_cmd),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  lpna_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_cmd),
    .empty          (fifo_empty),
    .pop            (fifo_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_nal_begin  (out_nal_begin),
    .out_nal_finish (out_nal_finish),
    .out_status     (out_status),
    .out_run_last   (out_run_last)
  );

  assign report_seen = out_valid && out_status;
  assign report_ok   = out_run_last && (out_out_byte == SC_ZERO) &&
                       !out_nal_begin && !out_nal_finish;
  assign begin_seen  = out_valid && out_nal_begin;
  assign begin_ok    = !out_run_last && (out_out_byte == SC_ZERO);
  assign begin_fire  = out_valid && out_ready && out_nal_begin;
  assign sc_mid_ok   = out_valid && (out_out_byte == SC_ZERO) && !out_run_last &&
                       !out_nal_begin;

  `ASSERT_IMP(a_no_overflow, clk, rst_n, fifo_push, !fifo_full, "command pushed into full queue")
  `ASSERT_IMP(a_report_shape, clk, rst_n, report_seen, report_ok, "malformed size report")
  `ASSERT_IMP(a_begin_not_last, clk, rst_n, begin_seen, begin_ok, "start code head marked last")
  `ASSERT_NXT(a_start_follows, clk, rst_n, begin_fire, sc_mid_ok, "start code interrupted")

endmodule

`default_nettype wire
